[rtl/core/binary_to_ascii_number_formatter_assert.svh]
// Assertion macros for the number formatter.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef BINARY_TO_ASCII_NUMBER_FORMATTER_ASSERT_SVH
`define BINARY_TO_ASCII_NUMBER_FORMATTER_ASSERT_SVH

// condition must never hold
`define B2A_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define B2A_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/b2a_pkg.sv]
// Shared types, constants and helpers for the number formatter.
// No dependencies; imported by b2a_ctrl, b2a_dp, the top level and the verification files.
`default_nettype none

package b2a_pkg;

    typedef enum logic [1:0] {
        FMT_UDEC  = 2'd0,
        FMT_SDEC  = 2'd1,
        FMT_HEX8  = 2'd2,
        FMT_HEX16 = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    localparam int DEC_DIGITS = 5;
    localparam int RECIP_SHIFT = 19;
    localparam logic [15:0] RECIP_TEN = 16'd52429;

    localparam logic [6:0] CHAR_ZERO  = 7'h30;
    localparam logic [6:0] CHAR_A     = 7'h41;
    localparam logic [6:0] CHAR_MINUS = 7'h2D;

    typedef struct packed {
        logic load_item;
        logic div_step;
        logic emit_char;
    } ctl_cmd_t;

    typedef struct packed {
        logic dec_in;
        logic conv_done;
        logic last_char;
        logic out_free;
    } ctl_sts_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return CHAR_ZERO + 7'(nib);
        end
        return CHAR_A + 7'(nib - 4'd10);
    endfunction

endpackage

`default_nettype wire

[rtl/core/b2a_num_if.sv]
// Input channel: one number and its format per word.
// Depends on nothing.
`default_nettype none

interface b2a_num_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

[rtl/core/b2a_chr_if.sv]
// Output channel: one ASCII character per word with a last marker.
// Depends on nothing.
`default_nettype none

interface b2a_chr_if;
    logic       valid;
    logic       ready;
    logic [6:0] ascii_char;
    logic       last;

    modport source (output valid, output ascii_char, output last, input ready);
    modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

`default_nettype wire

[rtl/core/b2a_ctrl.sv]
// Controller state machine: accept, divide-by-ten steps, character emission.
// Depends on b2a_pkg.
`default_nettype none

module b2a_ctrl
    import b2a_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_ready,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = sts.dec_in ? ST_CONV : ST_EMIT;
                end
            end
            ST_CONV:
            begin
                if (sts.conv_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.last_char)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_ready    = 1'b0;
        cmd.load_item = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.emit_char = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready    = 1'b1;
                cmd.load_item = item_valid;
            end
            ST_CONV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_char = sts.out_free;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/b2a_dp.sv]
// Datapath: operand registers, reciprocal divide-by-ten, digit store,
// character select and the output register. Depends on b2a_pkg.
`default_nettype none

module b2a_dp
    import b2a_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] value,
    input  wire ctl_cmd_t    cmd,
    output ctl_sts_t         sts,
    output logic             valid,
    input  wire logic        ready,
    output logic [6:0]       ascii_char,
    output logic             last
);

    fmt_t        func_reg;
    logic [15:0] val_reg;
    logic [15:0] mag_reg;
    logic        neg_reg;
    logic [3:0]  digs_reg [DEC_DIGITS];
    logic [2:0]  div_cnt_reg;
    logic [2:0]  pos_reg;
    logic        valid_reg;
    logic [6:0]  char_reg;
    logic        last_reg;

    logic        neg_in;
    logic [31:0] prod;
    logic [12:0] quot;
    logic [15:0] quot_x10;
    logic [15:0] rem;
    logic [2:0]  sig;
    logic [2:0]  nchar;
    logic [2:0]  dig_pos;
    logic [2:0]  dig_idx;
    logic [3:0]  dig;
    logic [1:0]  nib_sel;
    logic [3:0]  nib;
    logic [6:0]  char_sel;

    assign neg_in   = (fmt_t'(func) == FMT_SDEC) && value[15];
    assign prod     = 32'(mag_reg) * 32'(RECIP_TEN);
    assign quot     = prod[31:RECIP_SHIFT];
    assign quot_x10 = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
    assign rem      = mag_reg - quot_x10;

    always_comb
    begin
        sig = 3'd1;
        for (int i = 1; i < DEC_DIGITS; i++)
        begin
            if (digs_reg[i] != 4'd0)
            begin
                sig = 3'(i + 1);
            end
        end
    end

    always_comb
    begin
        case (func_reg)
            FMT_HEX8:  nchar = 3'd2;
            FMT_HEX16: nchar = 3'd4;
            default:   nchar = sig + 3'(neg_reg);
        endcase
    end

    assign dig_pos = pos_reg - 3'(neg_reg);
    assign dig_idx = sig - 3'd1 - dig_pos;

    always_comb
    begin
        case (dig_idx)
            3'd0:    dig = digs_reg[0];
            3'd1:    dig = digs_reg[1];
            3'd2:    dig = digs_reg[2];
            3'd3:    dig = digs_reg[3];
            3'd4:    dig = digs_reg[4];
            default: dig = 4'd0;
        endcase
    end

    assign nib_sel = (func_reg == FMT_HEX8) ? (pos_reg[1:0] + 2'd2) : pos_reg[1:0];

    always_comb
    begin
        case (nib_sel)
            2'd0:    nib = val_reg[15:12];
            2'd1:    nib = val_reg[11:8];
            2'd2:    nib = val_reg[7:4];
            default: nib = val_reg[3:0];
        endcase
    end

    always_comb
    begin
        if (func_reg[1])
        begin
            char_sel = hex_char(nib);
        end
        else if (neg_reg && (pos_reg == 3'd0))
        begin
            char_sel = CHAR_MINUS;
        end
        else
        begin
            char_sel = CHAR_ZERO + 7'(dig);
        end
    end

    assign sts.dec_in    = !func[1];
    assign sts.conv_done = (div_cnt_reg == 3'(DEC_DIGITS - 1));
    assign sts.last_char = (pos_reg == (nchar - 3'd1));
    assign sts.out_free  = !valid_reg || ready;

    // operand, digit and output character registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg <= fmt_t'(func);
            val_reg  <= value;
            neg_reg  <= neg_in;
            mag_reg  <= neg_in ? (~value + 16'd1) : value;
        end
        else if (cmd.div_step)
        begin
            mag_reg <= 16'(quot);
            for (int i = 0; i < DEC_DIGITS - 1; i++)
            begin
                digs_reg[i] <= digs_reg[i + 1];
            end
            digs_reg[DEC_DIGITS - 1] <= rem[3:0];
        end
        if (cmd.emit_char)
        begin
            char_reg <= char_sel;
            last_reg <= sts.last_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= 3'd0;
            pos_reg     <= 3'd0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                div_cnt_reg <= 3'd0;
                pos_reg     <= 3'd0;
            end
            else
            begin
                if (cmd.div_step)
                begin
                    div_cnt_reg <= div_cnt_reg + 3'd1;
                end
                if (cmd.emit_char)
                begin
                    pos_reg <= pos_reg + 3'd1;
                end
            end
            if (cmd.emit_char)
            begin
                valid_reg <= 1'b1;
            end
            else if (ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign valid      = valid_reg;
    assign ascii_char = char_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

[rtl/core/binary_to_ascii_number_formatter.sv]
// Top level of the binary to ASCII number formatter.
// Depends on b2a_pkg, b2a_num_if, b2a_chr_if, b2a_ctrl, b2a_dp and the assert header.
//
//   channel | dir | word payload          | handshake
//   --------+-----+-----------------------+--------------
//   num     | in  | func[1:0], value[15:0] | valid / ready
//   chr     | out | ascii_char[6:0], last  | valid / ready
//
// Decimal: accept, then a divide-by-ten step per digit slot (five slots) through one
// reciprocal multiplier, then 1 to 6 characters, one per cycle while chr is not stalled.
// Hex: accept, then 2 or 4 characters at the same rate.
// One output register; a stalled chr channel holds emission, num stays not ready.
// rst_n clears the state machine, counters and output valid asynchronously.
`default_nettype none

module binary_to_ascii_number_formatter
    import b2a_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    b2a_num_if.sink   num,
    b2a_chr_if.source chr
);

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    b2a_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (num.valid),
        .item_ready (num.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    b2a_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .func       (num.func),
        .value      (num.value),
        .cmd        (cmd),
        .sts        (sts),
        .valid      (chr.valid),
        .ready      (chr.ready),
        .ascii_char (chr.ascii_char),
        .last       (chr.last)
    );

`include "binary_to_ascii_number_formatter_assert.svh"

    `B2A_ASSERT_NEXT(a_busy_after_accept, num.valid && num.ready, !num.ready, "ready after accept")
    `B2A_ASSERT_NEXT(a_last_loaded, cmd.emit_char && sts.last_char, chr.valid && chr.last, "last lost")
    `B2A_ASSERT_NEVER(a_load_vs_emit, cmd.load_item && (cmd.emit_char || cmd.div_step), "cmd clash")

endmodule

`default_nettype wire

[verif/b2a_formatter_checker.sv]
// Checker for the number formatter: predicts the characters of every accepted number
// and compares them with the character channel in order.
// Depends on b2a_pkg, b2a_num_if and b2a_chr_if.
module b2a_formatter_checker
    import b2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    b2a_num_if          num,
    b2a_chr_if          chr,
    output int unsigned mismatches,
    output int unsigned pending,
    output int unsigned numbers_seen,
    output int unsigned chars_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [6:0] ascii_char;
        logic       last;
    } char_word_t;

    char_word_t  expected_chars[$];
    string       hex_digits = "0123456789ABCDEF";
    int unsigned mismatch_count = 0;
    int unsigned number_count = 0;
    int unsigned char_count = 0;

    task automatic push_char(input logic [6:0] c);
        char_word_t w;
        w.ascii_char = c;
        w.last = 1'b0;
        expected_chars.push_back(w);
    endtask

    task automatic push_decimal(input logic [15:0] mag);
        logic [3:0]  digits [5];
        logic [15:0] rest;
        int          n;
        int          j;
        rest = mag;
        n = 0;
        if (rest == 16'd0)
        begin
            push_char(CHAR_ZERO);
        end
        else
        begin
            while (rest != 16'd0)
            begin
                digits[n] = 4'(rest % 16'd10);
                rest = rest / 16'd10;
                n++;
            end
            for (j = n - 1; j >= 0; j--)
            begin
                push_char(CHAR_ZERO + 7'(digits[j]));
            end
        end
    endtask

    task automatic push_hex(input logic [15:0] v, input int nibbles);
        int j;
        for (j = nibbles - 1; j >= 0; j--)
        begin
            push_char(7'(hex_digits[v[4*j +: 4]]));
        end
    endtask

    task automatic predict_number(input fmt_t f, input logic [15:0] v);
        logic [15:0] magnitude;
        magnitude = ~v + 16'd1;
        case (f)
            FMT_UDEC:
            begin
                push_decimal(v);
            end
            FMT_SDEC:
            begin
                if (v[15])
                begin
                    push_char(CHAR_MINUS);
                    push_decimal(magnitude);
                end
                else
                begin
                    push_decimal(v);
                end
            end
            FMT_HEX8:
            begin
                push_hex(v, 2);
            end
            default:
            begin
                push_hex(v, 4);
            end
        endcase
        expected_chars[expected_chars.size() - 1].last = 1'b1;
    endtask

    task automatic check_char(input logic [6:0] c, input logic l);
        char_word_t w;
        char_count++;
        if (expected_chars.size() == 0)
        begin
            if (mismatch_count < 10)
            begin
                $display("%0t: unexpected char %h last %b with nothing pending", $realtime, c, l);
            end
            mismatch_count++;
        end
        else
        begin
            w = expected_chars.pop_front();
            if (c !== w.ascii_char || l !== w.last)
            begin
                if (mismatch_count < 10)
                begin
                    $display("%0t: mismatch: expected char %h last %b, got char %h last %b",
                             $realtime, w.ascii_char, w.last, c, l);
                end
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (num.valid && num.ready)
            begin
                predict_number(fmt_t'(num.func), num.value);
                number_count++;
            end
            if (chr.valid && chr.ready)
            begin
                check_char(chr.ascii_char, chr.last);
            end
        end
        mismatches   <= mismatch_count;
        pending      <= expected_chars.size();
        numbers_seen <= number_count;
        chars_seen   <= char_count;
    end

endmodule

[verif/tb_binary_to_ascii_number_formatter.sv]
// Testbench top for the number formatter: clock, reset, number stimulus and
// character-side backpressure; checking lives in b2a_formatter_checker.
// Depends on b2a_pkg, b2a_num_if, b2a_chr_if and the formatter RTL.
module tb_binary_to_ascii_number_formatter;
    timeunit 1ns;
    timeprecision 1ps;

    import b2a_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 150;
    localparam int RANDOM_ITEMS   = 80;
    localparam int QUIET_ITEMS    = 30;

    logic        clk = 1'b0;
    logic        rst_n;
    bit          idle_on = 1'b0;
    bit          long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;
    int unsigned idle_cycles;
    int unsigned mismatches;
    int unsigned pending;
    int unsigned numbers_seen;
    int unsigned chars_seen;

    b2a_num_if num_ch();
    b2a_chr_if chr_ch();

    always #2 clk = ~clk;

    binary_to_ascii_number_formatter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .num   (num_ch),
        .chr   (chr_ch)
    );

    b2a_formatter_checker i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .num          (num_ch),
        .chr          (chr_ch),
        .mismatches   (mismatches),
        .pending      (pending),
        .numbers_seen (numbers_seen),
        .chars_seen   (chars_seen)
    );

    task automatic send_number(input fmt_t f, input logic [15:0] v);
        num_ch.valid <= 1'b1;
        num_ch.func  <= f;
        num_ch.value <= v;
        do
        begin
            @(posedge clk);
        end
        while (!num_ch.ready);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            num_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        num_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(0, 4))
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 9));
            2: v = 16'($urandom_range(10, 9999));
            3:
            begin
                case ($urandom_range(0, 5))
                    0: v = 16'h0000;
                    1: v = 16'h7FFF;
                    2: v = 16'h8000;
                    3: v = 16'hFFFF;
                    4: v = 16'd9999;
                    default: v = 16'd10000;
                endcase
            end
            default: v = 16'd0 - 16'($urandom_range(1, 1000));
        endcase
        return v;
    endfunction

    initial
    begin
        chr_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req && !long_hold_done)
            begin
                chr_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                chr_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                chr_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((num_ch.valid && num_ch.ready) || (chr_ch.valid && chr_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL binary_to_ascii_number_formatter");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        num_ch.valid <= 1'b0;
        num_ch.func  <= FMT_UDEC;
        num_ch.value <= 16'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        send_number(FMT_UDEC, 16'd0);
        send_number(FMT_UDEC, 16'd65535);
        send_number(FMT_UDEC, 16'd1);
        send_number(FMT_UDEC, 16'd9);
        send_number(FMT_UDEC, 16'd10);
        send_number(FMT_UDEC, 16'd12345);
        send_number(FMT_SDEC, 16'd0);
        send_number(FMT_SDEC, 16'h7FFF);
        send_number(FMT_SDEC, 16'h8000);
        send_number(FMT_SDEC, 16'hFFFF);
        send_number(FMT_SDEC, 16'd5);
        send_number(FMT_SDEC, 16'hFFF6);
        send_number(FMT_HEX8, 16'h0000);
        send_number(FMT_HEX8, 16'hABFF);
        send_number(FMT_HEX8, 16'h12C3);
        send_number(FMT_HEX16, 16'h0000);
        send_number(FMT_HEX16, 16'hFFFF);
        send_number(FMT_HEX16, 16'h1234);
        send_number(FMT_HEX16, 16'hA5F0);
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 25)
            begin
                long_hold_req = 1'b1;
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
            begin
                idle_on = 1'b0;
            end
            send_number(fmt_t'($urandom_range(0, 3)), pick_value());
        end
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Sent %0d numbers over all four formats, with zero, extremes and most negative,",
                 numbers_seen);
        $display("and checked %0d characters under random stalls and a long output hold.",
                 chars_seen);
        if (mismatches == 0 && pending == 0)
        begin
            $display("PASS binary_to_ascii_number_formatter");
        end
        else
        begin
            $display("%0d mismatches, %0d characters never arrived", mismatches, pending);
            $display("FAIL binary_to_ascii_number_formatter");
        end
        $finish;
    end

endmodule

[binary_to_ascii_number_formatter.f]
+incdir+rtl/core
rtl/core/b2a_pkg.sv
rtl/core/b2a_num_if.sv
rtl/core/b2a_chr_if.sv
rtl/core/b2a_ctrl.sv
rtl/core/b2a_dp.sv
rtl/core/binary_to_ascii_number_formatter.sv
verif/b2a_formatter_checker.sv
verif/tb_binary_to_ascii_number_formatter.sv
